// ===== sv/mvts_pkg.sv =====
package mvts_pkg;

  localparam int VALVES = 4;
  localparam int VIDX_W = (VALVES > 1) ? $clog2(VALVES) : 1;
  localparam int MAX_EVENTS = 8;
  localparam int EVIDX_W = $clog2(MAX_EVENTS);
  localparam int EVCNT_W = EVIDX_W + 1;

  // command codes carried in s_tuser
  localparam logic [2:0] FUNC_TICK      = 3'd0;
  localparam logic [2:0] FUNC_OPEN      = 3'd1;
  localparam logic [2:0] FUNC_CLOSE     = 3'd2;
  localparam logic [2:0] FUNC_CLOSE_ALL = 3'd3;
  localparam logic [2:0] FUNC_REPORT    = 3'd4;

  // valve modes, also the reported event state
  localparam logic [1:0] MODE_CLOSED = 2'd0;
  localparam logic [1:0] MODE_OPEN   = 2'd1;
  localparam logic [1:0] MODE_MOVING = 2'd2;

  // register indexes, decoded from paddr[2]
  localparam logic REG_TRANSITION_DELAY = 1'b0;
  localparam logic REG_MAX_DURATION     = 1'b1;

  localparam logic [7:0]  TRANSITION_DELAY_RST = 8'd15;
  localparam logic [15:0] MAX_DURATION_RST     = 16'd3600;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_TICK_T = 5'b00010,
    ST_TICK_C = 5'b00100,
    ST_CMD    = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        heading;
    logic        drive;
    logic [7:0]  tleft;
    logic        trun;
    logic [15:0] cleft;
    logic        crun;
  } valve_t;

endpackage

// ===== sv/multi_valve_timed_sequencer.sv =====
// Timed sequencer for VALVES motorized valves. Commands arrive on the s_ stream
// (s_tuser = func), result items leave on the m_ stream, one per reported event
// or a single item with has_event (m_tuser) low; m_tlast marks the final item.
// One per-valve step unit (a shared 16-bit countdown decrement/compare and the
// mode update) is walked over the valves by a small sequencer, one valve per
// cycle, and s_tready is low until the last result of an item is transferred.
// After a command is accepted, a tick runs a transition pass over all valves,
// then an auto-close pass; close all and report all run one pass over all
// valves, open or close steps only the addressed valve, and a rejected command
// steps none; then one result item (at least one) per cycle while m_tready is
// high. With 4 valves a tick gives 1 to 8 result items. Registers: transition_delay at
// address 0x0, max_duration at 0x4; write them only while idle.
module multi_valve_timed_sequencer (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // command stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // [3:0] valve_index, [19:4] open duration, rest zero
  input  logic [2:0]  s_tuser,  // [2:0] func
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // [3:0] event_valve, [5:4] event_state, [6] accepted,
                                // [10:7] drive_bits, rest zero
  output logic        m_tuser,  // [0] has_event
  output logic        m_tlast
);
  import mvts_pkg::*;

  state_t state;

  logic [7:0]  transition_delay;
  logic [15:0] max_duration;

  valve_t valves [VALVES];

  logic [2:0]        op;
  logic [15:0]       dur;
  logic              acc;
  logic [VIDX_W-1:0] vi;

  logic [3:0]         ev_valve [MAX_EVENTS];
  logic [1:0]         ev_state [MAX_EVENTS];
  logic [EVCNT_W-1:0] ev_cnt;
  logic [EVIDX_W-1:0] rd;

  valve_t      cur;
  valve_t      nxt;
  logic        push;
  logic [1:0]  push_st;
  logic        step_en;
  logic        vi_last;
  logic [15:0] cnt_in;
  logic [15:0] cnt_dec;
  logic        cnt_done;

  logic [3:0]  valve_index;
  logic [15:0] req_dur;
  logic        idx_ok;
  logic        s_xfer;
  logic        m_xfer;
  logic        cfg_wr;

  logic [3:0]  drive_bits;
  logic        has_event;
  logic        out_last;

  assign valve_index = s_tdata[3:0];
  assign req_dur     = s_tdata[19:4];
  assign idx_ok      = {1'b0, valve_index} < 5'(VALVES);
  assign s_tready    = (state == ST_IDLE);
  assign s_xfer      = s_tvalid && s_tready;
  assign m_tvalid    = (state == ST_EMIT);
  assign m_xfer      = m_tvalid && m_tready;

  // APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_MAX_DURATION) ? {16'b0, max_duration}
                                                 : {24'b0, transition_delay};

  always_ff @(posedge clk) begin
    if (rst) begin
      transition_delay <= TRANSITION_DELAY_RST;
      max_duration     <= MAX_DURATION_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MAX_DURATION) begin
        max_duration <= pwdata[15:0];
      end else begin
        transition_delay <= pwdata[7:0];
      end
    end
  end

  // shared step unit on the valve selected by vi
  assign cur      = valves[vi];
  assign vi_last  = (vi == VIDX_W'(VALVES - 1));
  assign step_en  = (state == ST_TICK_T) || (state == ST_TICK_C) || (state == ST_CMD);
  assign cnt_in   = (state == ST_TICK_T) ? {8'b0, cur.tleft} : cur.cleft;
  assign cnt_dec  = cnt_in - 16'd1;
  assign cnt_done = (cnt_in <= 16'd1);

  always_comb begin
    nxt     = cur;
    push    = 1'b0;
    push_st = cur.mode;
    unique case (state)
      ST_TICK_T: begin
        if (cur.trun) begin
          if (cnt_done) begin
            nxt.tleft = 8'd0;
            nxt.trun  = 1'b0;
            nxt.mode  = cur.heading ? MODE_OPEN : MODE_CLOSED;
            push      = 1'b1;
            push_st   = nxt.mode;
          end else begin
            nxt.tleft = cnt_dec[7:0];
          end
        end
      end
      ST_TICK_C: begin
        if (cur.crun) begin
          if (cnt_done) begin
            nxt.cleft   = 16'd0;
            nxt.crun    = 1'b0;
            nxt.drive   = 1'b0;
            nxt.heading = 1'b0;
            nxt.mode    = MODE_MOVING;
            nxt.tleft   = transition_delay;
            nxt.trun    = 1'b1;
            push        = 1'b1;
            push_st     = MODE_MOVING;
          end else begin
            nxt.cleft = cnt_dec;
          end
        end
      end
      ST_CMD: begin
        case (op) inside
          FUNC_OPEN: begin
            nxt.cleft = dur;
            nxt.crun  = 1'b1;
            if (cur.mode != MODE_OPEN) begin
              nxt.drive   = 1'b1;
              nxt.heading = 1'b1;
              nxt.mode    = MODE_MOVING;
              nxt.tleft   = transition_delay;
              nxt.trun    = 1'b1;
              push        = 1'b1;
              push_st     = MODE_MOVING;
            end
          end
          FUNC_CLOSE, FUNC_CLOSE_ALL: begin
            nxt.cleft = 16'd0;
            nxt.crun  = 1'b0;
            if (cur.mode != MODE_CLOSED) begin
              nxt.drive   = 1'b0;
              nxt.heading = 1'b0;
              nxt.mode    = MODE_MOVING;
              nxt.tleft   = transition_delay;
              nxt.trun    = 1'b1;
              push        = 1'b1;
              push_st     = MODE_MOVING;
            end
          end
          FUNC_REPORT: begin
            push = 1'b1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VALVES; i++) begin
        valves[i] <= '0;
      end
    end else if (step_en) begin
      valves[vi] <= nxt;
    end
  end

  // event buffer; events past the last slot are dropped
  always_ff @(posedge clk) begin
    if (step_en && push && (ev_cnt < EVCNT_W'(MAX_EVENTS))) begin
      ev_valve[ev_cnt[EVIDX_W-1:0]] <= 4'(vi);
      ev_state[ev_cnt[EVIDX_W-1:0]] <= push_st;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      op     <= FUNC_TICK;
      dur    <= '0;
      acc    <= 1'b0;
      vi     <= '0;
      ev_cnt <= '0;
      rd     <= '0;
    end else begin
      if (step_en && push && (ev_cnt < EVCNT_W'(MAX_EVENTS))) begin
        ev_cnt <= ev_cnt + EVCNT_W'(1);
      end
      unique case (state)
        ST_IDLE: begin
          if (s_xfer) begin
            op     <= s_tuser;
            dur    <= (req_dur > max_duration) ? max_duration : req_dur;
            ev_cnt <= '0;
            rd     <= '0;
            case (s_tuser) inside
              FUNC_TICK: begin
                acc   <= 1'b1;
                vi    <= '0;
                state <= ST_TICK_T;
              end
              FUNC_OPEN, FUNC_CLOSE: begin
                vi  <= valve_index[VIDX_W-1:0];
                acc <= idx_ok;
                if (idx_ok) begin
                  state <= ST_CMD;
                end else begin
                  state <= ST_EMIT;
                end
              end
              FUNC_CLOSE_ALL, FUNC_REPORT: begin
                acc   <= 1'b1;
                vi    <= '0;
                state <= ST_CMD;
              end
              default: begin
                acc   <= 1'b0;
                vi    <= '0;
                state <= ST_EMIT;
              end
            endcase
          end
        end
        ST_TICK_T: begin
          if (vi_last) begin
            vi    <= '0;
            state <= ST_TICK_C;
          end else begin
            vi <= vi + VIDX_W'(1);
          end
        end
        ST_TICK_C: begin
          vi <= vi + VIDX_W'(1);
          if (vi_last) begin
            state <= ST_EMIT;
          end
        end
        ST_CMD: begin
          vi <= vi + VIDX_W'(1);
          if (vi_last || op == FUNC_OPEN || op == FUNC_CLOSE) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (m_xfer) begin
            if (out_last) begin
              state <= ST_IDLE;
            end else begin
              rd <= rd + EVIDX_W'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result item
  always_comb begin
    drive_bits = '0;
    for (int i = 0; i < 4; i++) begin
      if (i < VALVES) begin
        drive_bits[i] = valves[i].drive;
      end
    end
  end

  assign has_event = (ev_cnt != '0);
  assign out_last  = !has_event || ({1'b0, rd} == ev_cnt - EVCNT_W'(1));
  assign m_tlast   = out_last;
  assign m_tuser   = has_event;
  assign m_tdata   = {5'b0, drive_bits, acc,
                      has_event ? ev_state[rd] : 2'b0,
                      has_event ? ev_valve[rd] : 4'b0};

endmodule
